[rtl/core/hrsp_pkg.sv]
// Package: shared types, codes and keyword tables of the HTTP request stream parser
`timescale 1ns / 1ps

package hrsp_pkg;

	// default width of the Content-Length accumulator and body counter
	localparam int LENGTH_BITS_DEF = 32;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// keyword lengths
	localparam logic [3:0] VERSION_LEN = 4'd8;
	localparam logic [3:0] CLEN_LEN    = 4'd14;
	localparam logic [3:0] CONN_LEN    = 4'd10;
	localparam logic [3:0] KA_LEN      = 4'd10;
	localparam logic [3:0] POS_MAX     = 4'd15;

	// version candidate mask bits
	localparam int VER_10 = 0;
	localparam int VER_11 = 1;

	typedef enum logic [3:0] {
		ST_PRE_METHOD      = 4'd0,
		ST_METHOD          = 4'd1,
		ST_PRE_URI         = 4'd2,
		ST_URI             = 4'd3,
		ST_PRE_VERSION     = 4'd4,
		ST_VERSION         = 4'd5,
		ST_REQ_EOL         = 4'd6,
		ST_PRE_KEY         = 4'd7,
		ST_KEY             = 4'd8,
		ST_PRE_VALUE       = 4'd9,
		ST_VALUE           = 4'd10,
		ST_HEADER_EOL      = 4'd11,
		ST_HEADERS_END_EOL = 4'd12,
		ST_DATA            = 4'd13
	} parse_state_t;

	typedef enum logic [2:0] {
		CLS_BLANK   = 3'd0,
		CLS_METHOD  = 3'd1,
		CLS_URI     = 3'd2,
		CLS_VERSION = 3'd3,
		CLS_NAME    = 3'd4,
		CLS_VALUE   = 3'd5,
		CLS_BODY    = 3'd6,
		CLS_DELIM   = 3'd7
	} byte_class_t;

	// one result transaction
	typedef struct packed {
		byte_class_t byte_class;
		logic [7:0]  byte_value;
		logic        token_end;
		logic        request_done;
		logic        parse_error;
		logic        keep_alive;
		logic        conn_open;
	} result_t;

	// "HTTP/1." shared prefix, last character chosen by candidate
	function automatic logic [7:0] version_char(input logic [3:0] pos, input logic minor);
		logic [7:0] c;
		case (pos)
			4'd0: c = "H";
			4'd1: c = "T";
			4'd2: c = "T";
			4'd3: c = "P";
			4'd4: c = "/";
			4'd5: c = "1";
			4'd6: c = ".";
			4'd7: c = minor ? "1" : "0";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] clen_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0:  c = "C";
			4'd1:  c = "o";
			4'd2:  c = "n";
			4'd3:  c = "t";
			4'd4:  c = "e";
			4'd5:  c = "n";
			4'd6:  c = "t";
			4'd7:  c = "-";
			4'd8:  c = "L";
			4'd9:  c = "e";
			4'd10: c = "n";
			4'd11: c = "g";
			4'd12: c = "t";
			4'd13: c = "h";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] conn_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0: c = "C";
			4'd1: c = "o";
			4'd2: c = "n";
			4'd3: c = "n";
			4'd4: c = "e";
			4'd5: c = "c";
			4'd6: c = "t";
			4'd7: c = "i";
			4'd8: c = "o";
			4'd9: c = "n";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] ka_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0: c = "K";
			4'd1: c = "e";
			4'd2: c = "e";
			4'd3: c = "p";
			4'd4: c = "-";
			4'd5: c = "A";
			4'd6: c = "l";
			4'd7: c = "i";
			4'd8: c = "v";
			4'd9: c = "e";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

[rtl/core/hrsp_stream_if.sv]
// Interfaces: byte stream channel and parse result channel
`timescale 1ns / 1ps

interface hrsp_byte_if;
	import hrsp_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface hrsp_result_if;
	import hrsp_pkg::*;

	logic        valid;
	logic        ready;
	byte_class_t byte_class;
	logic [7:0]  byte_value;
	logic        token_end;
	logic        request_done;
	logic        parse_error;
	logic        keep_alive;
	logic        conn_open;

	modport source (
		output valid, output byte_class, output byte_value, output token_end,
		output request_done, output parse_error, output keep_alive, output conn_open,
		input ready
	);
	modport sink (
		input valid, input byte_class, input byte_value, input token_end,
		input request_done, input parse_error, input keep_alive, input conn_open,
		output ready
	);
endinterface

[rtl/core/hrsp_in_stage.sv]
// Input register stage: captures one received byte per transaction
`timescale 1ns / 1ps

module hrsp_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	hrsp_byte_if.sink  rx,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] data_s1
);
	import hrsp_pkg::*;

	// take a new byte when the stage is empty or its byte moves on this cycle
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	// hold the payload until it is consumed
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			data_s1 <= rx.data_byte;
		end
	end

endmodule

[rtl/core/hrsp_parse_core.sv]
// Parser core: request state machine, keyword matchers and length accumulator
`timescale 1ns / 1ps

module hrsp_parse_core #(
	parameter int LENGTH_BITS = hrsp_pkg::LENGTH_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [7:0]       data_s1,
	output hrsp_pkg::result_t result
);
	import hrsp_pkg::*;

	localparam int ACC_W = LENGTH_BITS + 4;

	parse_state_t           state_q, state_n;
	logic                   keep_q, keep_n;
	logic                   open_q, open_n;
	logic [LENGTH_BITS-1:0] body_q, body_n;
	logic [3:0]             pos_q, pos_n;
	logic                   is_len_q, is_len_n;
	logic                   is_conn_q, is_conn_n;
	logic                   is_ka_q, is_ka_n;
	logic [1:0]             ver_q, ver_n;
	logic [LENGTH_BITS-1:0] acc_q, acc_n;
	logic                   digits_q, digits_n;

	logic                   blank, pre_state, is_digit;
	logic [3:0]             pos_inc;
	logic [ACC_W-1:0]       acc_prod;
	logic [LENGTH_BITS-1:0] acc_next;
	logic [LENGTH_BITS-1:0] body_dec;
	parse_state_t           tok_state;
	byte_class_t            cls;
	logic                   tend, done, err;

	assign blank    = (data_s1 == CH_SP) || (data_s1 == CH_TAB);
	assign is_digit = (data_s1 >= CH_ZERO) && (data_s1 <= CH_NINE);
	assign pos_inc  = (pos_q < POS_MAX) ? pos_q + 4'd1 : pos_q;
	assign body_dec = (body_q != '0) ? body_q - {{(LENGTH_BITS-1){1'b0}}, 1'b1} : body_q;

	// accumulate a decimal digit as acc*8 + acc*2 + digit, saturating on overflow
	assign acc_prod = ({4'b0000, acc_q} << 3) + ({4'b0000, acc_q} << 1)
		+ {{(ACC_W-4){1'b0}}, data_s1[3:0]};
	assign acc_next = (acc_prod[ACC_W-1:LENGTH_BITS] != 4'b0000) ? '1
		: acc_prod[LENGTH_BITS-1:0];

	// map a blank-skipping state to the token state that follows it
	always_comb begin
		pre_state = 1'b1;
		case (state_q)
			ST_PRE_METHOD:  tok_state = ST_METHOD;
			ST_PRE_URI:     tok_state = ST_URI;
			ST_PRE_VERSION: tok_state = ST_VERSION;
			ST_PRE_KEY:     tok_state = ST_KEY;
			ST_PRE_VALUE:   tok_state = ST_VALUE;
			default: begin
				pre_state = 1'b0;
				tok_state = state_q;
			end
		endcase
	end

	// next state and result of one byte
	always_comb begin
		state_n   = state_q;
		keep_n    = keep_q;
		open_n    = open_q;
		body_n    = body_q;
		pos_n     = pos_q;
		is_len_n  = is_len_q;
		is_conn_n = is_conn_q;
		is_ka_n   = is_ka_q;
		ver_n     = ver_q;
		acc_n     = acc_q;
		digits_n  = digits_q;
		cls       = CLS_BLANK;
		tend      = 1'b0;
		done      = 1'b0;
		err       = 1'b0;

		if (open_q && !(pre_state && blank)) begin
			if (state_q == ST_PRE_KEY && data_s1 == CH_CR) begin
				// blank line: end of the header block
				cls     = CLS_DELIM;
				state_n = ST_HEADERS_END_EOL;
			end else begin
				state_n = tok_state;
				case (tok_state)
					ST_METHOD, ST_URI: begin
						if (data_s1 == CH_SP) begin
							cls  = CLS_DELIM;
							tend = 1'b1;
							if (tok_state == ST_URI) begin
								state_n   = ST_PRE_VERSION;
								pos_n     = 4'd0;
								is_ka_n   = 1'b1;
								acc_n     = '0;
								digits_n  = 1'b1;
								ver_n     = 2'b11;
								is_len_n  = 1'b1;
								is_conn_n = 1'b1;
							end else begin
								state_n = ST_PRE_URI;
							end
						end else if (data_s1 == CH_CR) begin
							err = 1'b1;
						end else begin
							cls = (tok_state == ST_METHOD) ? CLS_METHOD : CLS_URI;
						end
					end
					ST_VERSION: begin
						if (data_s1 == CH_CR) begin
							if (pos_q == VERSION_LEN && ver_q[VER_10]) begin
								keep_n  = 1'b0;
								body_n  = '0;
								cls     = CLS_DELIM;
								tend    = 1'b1;
								state_n = ST_REQ_EOL;
							end else if (pos_q == VERSION_LEN && ver_q[VER_11]) begin
								keep_n  = 1'b1;
								body_n  = '0;
								cls     = CLS_DELIM;
								tend    = 1'b1;
								state_n = ST_REQ_EOL;
							end else begin
								err = 1'b1;
							end
						end else if (data_s1 == CH_SP) begin
							err = 1'b1;
						end else begin
							cls = CLS_VERSION;
							if (pos_q < VERSION_LEN) begin
								if (data_s1 != version_char(pos_q, 1'b0)) ver_n[VER_10] = 1'b0;
								if (data_s1 != version_char(pos_q, 1'b1)) ver_n[VER_11] = 1'b0;
							end else begin
								ver_n = 2'b00;
							end
							pos_n = pos_inc;
						end
					end
					ST_REQ_EOL, ST_HEADER_EOL: begin
						if (data_s1 == CH_LF) begin
							cls       = CLS_DELIM;
							state_n   = ST_PRE_KEY;
							pos_n     = 4'd0;
							is_ka_n   = 1'b1;
							acc_n     = '0;
							digits_n  = 1'b1;
							ver_n     = 2'b11;
							is_len_n  = 1'b1;
							is_conn_n = 1'b1;
						end else begin
							err = 1'b1;
						end
					end
					ST_KEY: begin
						if (data_s1 == CH_COLON) begin
							cls  = CLS_DELIM;
							tend = 1'b1;
							if (pos_q != CLEN_LEN) is_len_n = 1'b0;
							if (pos_q != CONN_LEN) is_conn_n = 1'b0;
							pos_n    = 4'd0;
							is_ka_n  = 1'b1;
							acc_n    = '0;
							digits_n = 1'b1;
							state_n  = ST_PRE_VALUE;
						end else if (data_s1 == CH_CR) begin
							err = 1'b1;
						end else begin
							cls = CLS_NAME;
							if (pos_q >= CLEN_LEN || data_s1 != clen_char(pos_q)) is_len_n = 1'b0;
							if (pos_q >= CONN_LEN || data_s1 != conn_char(pos_q)) is_conn_n = 1'b0;
							pos_n = pos_inc;
						end
					end
					ST_VALUE: begin
						if (data_s1 == CH_CR) begin
							cls  = CLS_DELIM;
							tend = 1'b1;
							if (is_len_q) begin
								body_n = acc_q;
							end else if (is_conn_q && is_ka_q && pos_q == KA_LEN) begin
								keep_n = 1'b1;
							end
							state_n = ST_HEADER_EOL;
						end else if (data_s1 == CH_LF) begin
							err = 1'b1;
						end else begin
							cls = CLS_VALUE;
							if (pos_q >= KA_LEN || data_s1 != ka_char(pos_q)) is_ka_n = 1'b0;
							pos_n = pos_inc;
							if (digits_q && is_digit) begin
								acc_n = acc_next;
							end else begin
								digits_n = 1'b0;
							end
						end
					end
					ST_HEADERS_END_EOL: begin
						if (data_s1 == CH_LF) begin
							cls = CLS_DELIM;
							if (body_q == '0) begin
								done = 1'b1;
							end else begin
								state_n = ST_DATA;
							end
						end else begin
							err = 1'b1;
						end
					end
					ST_DATA: begin
						cls    = CLS_BODY;
						body_n = body_dec;
						if (body_dec == '0) done = 1'b1;
					end
					default: begin
						err = 1'b1;
					end
				endcase

				// close on error; restart or close at the end of a request
				if (err) begin
					cls    = CLS_DELIM;
					tend   = 1'b0;
					keep_n = 1'b0;
					open_n = 1'b0;
				end else if (done) begin
					body_n = '0;
					if (keep_n) begin
						state_n   = ST_PRE_METHOD;
						pos_n     = 4'd0;
						is_ka_n   = 1'b1;
						acc_n     = '0;
						digits_n  = 1'b1;
						ver_n     = 2'b11;
						is_len_n  = 1'b1;
						is_conn_n = 1'b1;
					end else begin
						open_n = 1'b0;
					end
				end
			end
		end
	end

	// drive the result of the current byte
	always_comb begin
		result.byte_class   = cls;
		result.byte_value   = data_s1;
		result.token_end    = tend;
		result.request_done = done;
		result.parse_error  = err;
		result.keep_alive   = keep_n;
		result.conn_open    = open_n;
	end

	// advance the parser state once per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_PRE_METHOD;
			keep_q    <= 1'b0;
			open_q    <= 1'b1;
			body_q    <= '0;
			pos_q     <= 4'd0;
			is_len_q  <= 1'b1;
			is_conn_q <= 1'b1;
			is_ka_q   <= 1'b1;
			ver_q     <= 2'b11;
			acc_q     <= '0;
			digits_q  <= 1'b1;
		end else if (advance) begin
			state_q   <= state_n;
			keep_q    <= keep_n;
			open_q    <= open_n;
			body_q    <= body_n;
			pos_q     <= pos_n;
			is_len_q  <= is_len_n;
			is_conn_q <= is_conn_n;
			is_ka_q   <= is_ka_n;
			ver_q     <= ver_n;
			acc_q     <= acc_n;
			digits_q  <= digits_n;
		end
	end

endmodule

[rtl/core/hrsp_out_stage.sv]
// Output register stage: holds one result transaction until it is taken
`timescale 1ns / 1ps

module hrsp_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  hrsp_pkg::result_t  result,
	output logic               space,
	hrsp_result_if.source      tx
);
	import hrsp_pkg::*;

	logic    valid_s2;
	result_t result_s2;

	// room for a new result when empty or the held one leaves now
	assign space = !valid_s2 || tx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (space) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_s2 <= result;
		end
	end

	assign tx.valid        = valid_s2;
	assign tx.byte_class   = result_s2.byte_class;
	assign tx.byte_value   = result_s2.byte_value;
	assign tx.token_end    = result_s2.token_end;
	assign tx.request_done = result_s2.request_done;
	assign tx.parse_error  = result_s2.parse_error;
	assign tx.keep_alive   = result_s2.keep_alive;
	assign tx.conn_open    = result_s2.conn_open;

endmodule

[rtl/core/http_request_stream_parser.sv]
// Top level: HTTP/1.x request stream parser, one byte per transaction
`timescale 1ns / 1ps

// Labels every received byte of a connection with its token class (method, URI,
// version, header name, header value, body, delimiter or skipped blank) and
// reports token ends, request completion, syntax errors, the keep-alive decision
// and whether the connection is still open. Throughput is one byte per clock
// cycle, sustained whenever the result side keeps taking transactions; an
// accepted byte reaches its result through the input register and the result
// register, with the next-state logic between them. The parser
// state advances only when a byte moves from the input register to the result
// register, so stalls on either side lose nothing. Once the connection closes
// (error, or end of a request without keep-alive) bytes are still passed
// through, labelled as blanks, until reset. LENGTH_BITS sets the width of the
// Content-Length accumulator, which saturates at its maximum.
module http_request_stream_parser #(
	parameter int LENGTH_BITS = hrsp_pkg::LENGTH_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	hrsp_byte_if.sink     rx_byte,
	hrsp_result_if.source parse_result
);
	import hrsp_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       space;
	logic       advance;
	result_t    result;

	// move a byte through the parser when the result register has room
	assign advance = valid_s1 && space;

	hrsp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	hrsp_parse_core #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_parse_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.data_s1 (data_s1),
		.result  (result)
	);

	hrsp_out_stage u_out_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.result (result),
		.space  (space),
		.tx     (parse_result)
	);

endmodule

[bench/http_request_stream_parser_tb.sv]
// Testbench: byte stream in, labelled byte transactions out, checked against an in-bench parser
`timescale 1ns / 1ps

module http_request_stream_parser_tb;
	import hrsp_pkg::*;

	localparam int LEN_BITS     = LENGTH_BITS_DEF;
	localparam int RANDOM_BYTES = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_MAX   = 100;

	logic clk;
	logic arst_n;

	hrsp_byte_if   rx_if ();
	hrsp_result_if res_if ();

	http_request_stream_parser #(
		.LENGTH_BITS(LEN_BITS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_byte     (rx_if),
		.parse_result(res_if)
	);

	// keywords the parser recognises
	string kw_v10  = "HTTP/1.0";
	string kw_v11  = "HTTP/1.1";
	string kw_clen = "Content-Length";
	string kw_conn = "Connection";
	string kw_ka   = "Keep-Alive";

	// bench copy of the parser state
	parse_state_t        pst;
	logic                keep_st;
	logic                open_st;
	logic [LEN_BITS-1:0] body_cnt;
	logic [LEN_BITS-1:0] len_acc;
	logic [3:0]          mpos;
	logic                nm_len;
	logic                nm_conn;
	logic                val_ka;
	logic [1:0]          ver_mask;
	logic                dig_on;

	logic [7:0] conn_bytes[$];
	result_t    expected_labels[$];
	int         total_bytes;
	int         bytes_taken;
	int         mismatch_cnt;
	int         cycle_cnt;
	bit         byte_moved;

	// ---------------------------------------------------------------- parser model

	function automatic void clear_value_match();
		mpos    = '0;
		val_ka  = 1'b1;
		len_acc = '0;
		dig_on  = 1'b1;
	endfunction

	function automatic void clear_all_match();
		clear_value_match();
		ver_mask = 2'b11;
		nm_len   = 1'b1;
		nm_conn  = 1'b1;
	endfunction

	function automatic void reset_parser();
		pst      = ST_PRE_METHOD;
		keep_st  = 1'b0;
		body_cnt = '0;
		open_st  = 1'b1;
		clear_all_match();
	endfunction

	function automatic void bump_pos();
		if (mpos < POS_MAX) begin
			mpos = mpos + 4'd1;
		end
	endfunction

	// states that skip blanks ahead of a token
	function automatic bit gap_state(input parse_state_t st);
		return st == ST_PRE_METHOD || st == ST_PRE_URI || st == ST_PRE_VERSION ||
			st == ST_PRE_KEY || st == ST_PRE_VALUE;
	endfunction

	// advance the model by one byte and return the label it expects
	function automatic result_t label_byte(input logic [7:0] b);
		result_t             r;
		parse_state_t        st;
		byte_class_t         cls;
		logic                tend;
		logic                done;
		logic                err;
		logic [LEN_BITS-1:0] digit;
		cls  = CLS_BLANK;
		tend = 1'b0;
		done = 1'b0;
		err  = 1'b0;
		st   = pst;
		if (open_st && !(gap_state(st) && (b == CH_SP || b == CH_TAB))) begin
			if (st == ST_PRE_KEY && b == CH_CR) begin
				// blank line: header block ends
				cls = CLS_DELIM;
				pst = ST_HEADERS_END_EOL;
			end else begin
				if (gap_state(st)) begin
					st = parse_state_t'(st + 4'd1);
				end
				case (st)
					ST_METHOD, ST_URI: begin
						if (b == CH_SP) begin
							cls  = CLS_DELIM;
							tend = 1'b1;
							if (st == ST_URI) begin
								clear_all_match();
							end
							st = parse_state_t'(st + 4'd1);
						end else if (b == CH_CR) begin
							err = 1'b1;
						end else begin
							cls = (st == ST_METHOD) ? CLS_METHOD : CLS_URI;
						end
					end
					ST_VERSION: begin
						if (b == CH_CR) begin
							if (mpos == VERSION_LEN && ver_mask[VER_10]) begin
								keep_st = 1'b0;
							end else if (mpos == VERSION_LEN && ver_mask[VER_11]) begin
								keep_st = 1'b1;
							end else begin
								err = 1'b1;
							end
							if (!err) begin
								body_cnt = '0;
								cls      = CLS_DELIM;
								tend     = 1'b1;
								st       = ST_REQ_EOL;
							end
						end else if (b == CH_SP) begin
							err = 1'b1;
						end else begin
							cls = CLS_VERSION;
							if (mpos < VERSION_LEN) begin
								if (b != kw_v10[mpos]) ver_mask[VER_10] = 1'b0;
								if (b != kw_v11[mpos]) ver_mask[VER_11] = 1'b0;
							end else begin
								ver_mask = 2'b00;
							end
							bump_pos();
						end
					end
					ST_REQ_EOL, ST_HEADER_EOL: begin
						if (b == CH_LF) begin
							cls = CLS_DELIM;
							clear_all_match();
							st = ST_PRE_KEY;
						end else begin
							err = 1'b1;
						end
					end
					ST_KEY: begin
						if (b == CH_COLON) begin
							cls  = CLS_DELIM;
							tend = 1'b1;
							if (mpos != CLEN_LEN) nm_len = 1'b0;
							if (mpos != CONN_LEN) nm_conn = 1'b0;
							clear_value_match();
							st = ST_PRE_VALUE;
						end else if (b == CH_CR) begin
							err = 1'b1;
						end else begin
							cls = CLS_NAME;
							if (mpos >= CLEN_LEN || b != kw_clen[mpos]) nm_len = 1'b0;
							if (mpos >= CONN_LEN || b != kw_conn[mpos]) nm_conn = 1'b0;
							bump_pos();
						end
					end
					ST_VALUE: begin
						if (b == CH_CR) begin
							cls  = CLS_DELIM;
							tend = 1'b1;
							if (nm_len) begin
								body_cnt = len_acc;
							end else if (nm_conn && val_ka && mpos == KA_LEN) begin
								keep_st = 1'b1;
							end
							st = ST_HEADER_EOL;
						end else if (b == CH_LF) begin
							err = 1'b1;
						end else begin
							cls = CLS_VALUE;
							if (mpos >= KA_LEN || b != kw_ka[mpos]) val_ka = 1'b0;
							bump_pos();
							// accumulate leading digits, saturate at all ones
							if (dig_on && b >= CH_ZERO && b <= CH_NINE) begin
								digit = LEN_BITS'(b - CH_ZERO);
								if (len_acc > ({LEN_BITS{1'b1}} - digit) / 10) begin
									len_acc = {LEN_BITS{1'b1}};
								end else begin
									len_acc = LEN_BITS'(len_acc * 10 + digit);
								end
							end else begin
								dig_on = 1'b0;
							end
						end
					end
					ST_HEADERS_END_EOL: begin
						if (b == CH_LF) begin
							cls = CLS_DELIM;
							if (body_cnt == 0) begin
								done = 1'b1;
							end else begin
								st = ST_DATA;
							end
						end else begin
							err = 1'b1;
						end
					end
					ST_DATA: begin
						cls = CLS_BODY;
						if (body_cnt != 0) body_cnt = body_cnt - 1'b1;
						if (body_cnt == 0) done = 1'b1;
					end
					default: begin
						err = 1'b1;
					end
				endcase
				if (err) begin
					cls     = CLS_DELIM;
					tend    = 1'b0;
					keep_st = 1'b0;
					open_st = 1'b0;
				end else if (done) begin
					body_cnt = '0;
					if (keep_st) begin
						st = ST_PRE_METHOD;
						clear_all_match();
					end else begin
						open_st = 1'b0;
					end
				end
				pst = st;
			end
		end
		r.byte_class   = cls;
		r.byte_value   = b;
		r.token_end    = tend;
		r.request_done = done;
		r.parse_error  = err;
		r.keep_alive   = keep_st;
		r.conn_open    = open_st;
		return r;
	endfunction

	// ---------------------------------------------------------------- stream builder

	function automatic void push_byte(input logic [7:0] b);
		conn_bytes.push_back(b);
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			conn_bytes.push_back(s[i]);
		end
	endfunction

	function automatic void push_eol();
		push_byte(CH_CR);
		push_byte(CH_LF);
	endfunction

	function automatic void push_blanks(input int max_cnt);
		repeat ($urandom_range(max_cnt)) begin
			push_byte($urandom_range(1) ? CH_SP : CH_TAB);
		end
	endfunction

	// mostly printable, sometimes any byte, never one of the two banned
	function automatic void push_token(input logic [7:0] ban_a, input logic [7:0] ban_b,
			input int len, input bit first);
		logic [7:0] c;
		for (int i = 0; i < len; i++) begin
			do begin
				c = ($urandom_range(9) < 7) ? 8'($urandom_range(8'h7E, 8'h21))
					: 8'($urandom_range(255));
			end while (c == ban_a || c == ban_b ||
				(first && i == 0 && (c == CH_SP || c == CH_TAB)));
			push_byte(c);
		end
	endfunction

	function automatic void push_keep_alive_header();
		push_text("Connection:");
		push_blanks(2);
		push_text("Keep-Alive");
		push_eol();
	endfunction

	// Content-Length header whose value yields exactly n
	function automatic void push_length_header(input int unsigned n);
		push_text("Content-Length:");
		push_blanks(2);
		if (n == 0) begin
			case ($urandom_range(4))
				0: push_text("0");
				1: push_text("+9");
				2: push_text("-1");
				3: push_text("none");
				default: ;
			endcase
		end else begin
			case ($urandom_range(3))
				0: push_text($sformatf("00%0d", n));
				1: push_text($sformatf("%0d;q", n));
				2: push_text($sformatf("%0d ", n));
				default: push_text($sformatf("%0d", n));
			endcase
		end
		push_eol();
	endfunction

	// header that must leave keep-alive alone; a length decoy is flagged for override
	function automatic void push_noise_header(input bit closing, inout bit decoy_seen);
		string near_names[6] = '{"Content-Lengt", "Content-Length2", "content-length",
			"Connections", "Connectio", "Content-Length-Extra-Field"};
		string near_vals[6] = '{"keep-alive", "Keep-Alive!", "Keep-Aliv", "close",
			"Keep-Alive ", "Keep-Alive-Keep-Alive"};
		case ($urandom_range(4))
			0: begin
				push_token(CH_COLON, CH_CR, $urandom_range(20, 1), 1'b1);
				push_byte(CH_COLON);
				push_blanks(2);
				push_token(CH_CR, CH_LF, $urandom_range(20), 1'b0);
				push_eol();
			end
			1: begin
				push_text("Content-Length:");
				push_blanks(1);
				case ($urandom_range(4))
					0: push_text("99999999999999999999");
					1: push_text("4294967295");
					2: push_text("4294967296");
					3: push_text("-7");
					default: push_text($sformatf("%0d", $urandom));
				endcase
				push_eol();
				decoy_seen = 1'b1;
			end
			2: begin
				push_text(near_names[$urandom_range(5)]);
				push_byte(CH_COLON);
				push_blanks(1);
				push_text($urandom_range(1) ? "Keep-Alive" : $sformatf("%0d", $urandom_range(99)));
				push_eol();
			end
			3: begin
				push_text("Connection:");
				push_blanks(1);
				push_text(near_vals[$urandom_range(5)]);
				push_eol();
			end
			default: begin
				if (closing) begin
					push_text("Host: example");
					push_eol();
				end else begin
					push_keep_alive_header();
				end
			end
		endcase
	endfunction

	// one well-formed request; closing ones end the connection
	function automatic void push_request(input bit closing);
		string       methods[3] = '{"GET", "POST", "HEAD"};
		bit          v11;
		int          n_hdr;
		int          ka_slot;
		int          body_len;
		int          roll;
		bit          decoy_seen;
		v11        = closing ? 1'b0 : 1'($urandom_range(1));
		n_hdr      = $urandom_range(4);
		ka_slot    = (!v11 && !closing) ? $urandom_range(n_hdr) : -1;
		decoy_seen = 1'b0;
		roll       = $urandom_range(9);
		body_len   = (roll < 3) ? 0 : (roll < 9) ? $urandom_range(12, 1) : $urandom_range(60, 20);

		push_blanks(1);
		if ($urandom_range(3) == 0) begin
			push_token(CH_SP, CH_CR, $urandom_range(18, 1), 1'b1);
		end else begin
			push_text(methods[$urandom_range(2)]);
		end
		push_byte(CH_SP);
		push_blanks(2);
		push_byte("/");
		push_token(CH_SP, CH_CR, $urandom_range(20), 1'b0);
		push_byte(CH_SP);
		push_blanks(2);
		push_text(v11 ? "HTTP/1.1" : "HTTP/1.0");
		push_eol();
		for (int h = 0; h <= n_hdr; h++) begin
			if (h == ka_slot) push_keep_alive_header();
			if (h < n_hdr) push_noise_header(closing, decoy_seen);
		end
		if (body_len > 0 || decoy_seen || $urandom_range(3) == 0) begin
			push_length_header(body_len);
		end
		push_eol();
		repeat (body_len) push_byte(8'($urandom_range(255)));
	endfunction

	// end the connection by a close or a syntax error, then bytes that must be ignored
	function automatic void push_connection_end();
		string bad_ver[5] = '{"HTTP/1.2", "HTTP/1.10", "HTTP/1.", "http/1.1", "HTTP/1.1x"};
		case ($urandom_range(10))
			0: push_request(1'b1);
			1: begin
				push_text("GET");
				push_byte(CH_CR);
			end
			2: begin
				push_text("GET /x");
				push_byte(CH_CR);
			end
			3: begin
				push_text("GET / ");
				push_text(bad_ver[$urandom_range(4)]);
				push_byte(CH_CR);
			end
			4: begin
				push_text("GET / HTT");
				push_byte(CH_SP);
			end
			5: begin
				push_text("GET / HTTP/1.1");
				push_byte(CH_CR);
				push_byte("X");
			end
			6: begin
				push_text("GET / HTTP/1.1");
				push_eol();
				push_text("Host");
				push_byte(CH_CR);
			end
			7: begin
				push_text("GET / HTTP/1.1");
				push_eol();
				push_text("Host: a");
				push_byte(CH_LF);
			end
			8: begin
				push_text("GET / HTTP/1.1");
				push_eol();
				push_byte(CH_CR);
				push_byte("x");
			end
			9: begin
				push_text("GET / HTTP/1.1");
				push_eol();
				push_text("A: b");
				push_byte(CH_CR);
				push_byte("y");
			end
			default: push_byte(CH_CR);
		endcase
		repeat ($urandom_range(60, 30)) push_byte(8'($urandom_range(255)));
	endfunction

	// ---------------------------------------------------------------- clock, reset, stimulus

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// sender and receiver idle shares by phase of the run
	function automatic int idle_pct(input bit recv_side);
		int phase;
		phase = (total_bytes == 0) ? 0 : (bytes_taken * 3) / total_bytes;
		case (phase)
			0: return recv_side ? 60 : 18;
			1: return recv_side ? 18 : 60;
			default: return 0;
		endcase
	endfunction

	initial begin
		int base;
		arst_n           = 1'b0;
		rx_if.valid      = 1'b0;
		rx_if.data_byte  = 8'h00;
		res_if.ready     = 1'b0;
		bytes_taken      = 0;
		mismatch_cnt     = 0;
		byte_moved       = 1'b0;
		total_bytes      = 0;
		reset_parser();

		// directed: leading blanks, HTTP/1.0 kept alive by header, saturated then signed length
		push_byte(CH_TAB);
		push_text(" GET /a HTTP/1.0");
		push_eol();
		push_text("Connection:Keep-Alive");
		push_eol();
		push_text("Content-Length: 99999999999");
		push_eol();
		push_text("Content-Length:+4");
		push_eol();
		push_eol();
		// directed: HTTP/1.1, trailing junk after digits, body at byte extremes
		push_text("PUT / HTTP/1.1");
		push_eol();
		push_text("Content-Length: 3x");
		push_eol();
		push_eol();
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h80);

		// random kept-alive requests, then close the connection
		base = conn_bytes.size();
		while (conn_bytes.size() < base + RANDOM_BYTES) begin
			push_request(1'b0);
		end
		push_connection_end();
		total_bytes = conn_bytes.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: every byte taken, every label returned
		while (conn_bytes.size() != 0 || rx_if.valid || expected_labels.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// ---------------------------------------------------------------- driver

	// offer the next byte once the previous one has moved, idling at random; stall ready at random
	always @(negedge clk) begin
		if (arst_n && (!rx_if.valid || byte_moved)) begin
			byte_moved = 1'b0;
			if (conn_bytes.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
				rx_if.valid     <= 1'b1;
				rx_if.data_byte <= conn_bytes.pop_front();
			end else begin
				rx_if.valid <= 1'b0;
			end
		end
		res_if.ready <= arst_n && ($urandom_range(99) >= idle_pct(1'b1));
	end

	// predict the label of each accepted byte
	always @(posedge clk) begin
		if (arst_n && rx_if.valid && rx_if.ready) begin
			expected_labels.push_back(label_byte(rx_if.data_byte));
			bytes_taken++;
			byte_moved = 1'b1;
		end
	end

	// ---------------------------------------------------------------- monitor

	function automatic void check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatch_cnt++;
			// keep the log readable on a systematic failure
			if (mismatch_cnt <= REPORT_MAX) begin
				$error("%s: expected %0d, got %0d", field, want, got);
			end
		end
	endfunction

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin : label_check
		result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_labels.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= REPORT_MAX) begin
					$error("result transaction with none expected: byte_value %0d",
						res_if.byte_value);
				end
			end else begin
				want = expected_labels.pop_front();
				check_field("byte_class", 32'(want.byte_class), 32'(res_if.byte_class));
				check_field("byte_value", 32'(want.byte_value), 32'(res_if.byte_value));
				check_field("token_end", 32'(want.token_end), 32'(res_if.token_end));
				check_field("request_done", 32'(want.request_done),
					32'(res_if.request_done));
				check_field("parse_error", 32'(want.parse_error), 32'(res_if.parse_error));
				check_field("keep_alive", 32'(want.keep_alive), 32'(res_if.keep_alive));
				check_field("conn_open", 32'(want.conn_open), 32'(res_if.conn_open));
			end
		end
	end

	// hard stop on a hang
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial cycle_cnt = 0;

endmodule
